// ===== src/telemetry_frame_builder_assert.svh =====
// ----------------------------------------------------------------------------
// Telemetry frame builder assertion macros
// Shared concurrent assertion forms used by the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder package
// Frame geometry, register indexes, cell types and the battery scaling.
// ----------------------------------------------------------------------------
package tfb_pkg;

   // Frame geometry.
   localparam int FRAME_BYTES = 16;
   localparam int IDX_W       = 2;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] CSR_HEADER_BYTE    = 2'd0;
   localparam logic [IDX_W-1:0] CSR_OPTIONAL_SMALL = 2'd1;
   localparam logic [IDX_W-1:0] CSR_OPTIONAL_WORD  = 2'd2;

   // Whole frame as a row of bytes, byte 0 in the lowest slot.
   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   // Contents of one byte cell of the shift line.
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } cell_type;

   // Control shared by all cells.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // Battery percent: raw * 100 / 255, done as a reciprocal multiply.
   // For x below 65535, x / 255 equals (x + (x >> 8) + 1) >> 8.
   function automatic logic [6:0] battery_percent(input logic [7:0] raw);
      logic [14:0] prod;
      logic [15:0] sum;
      prod = 15'(raw) * 15'd100;
      sum  = 16'(prod) + 16'(prod[14:8]) + 16'd1;
      return sum[14:8];
   endfunction

endpackage

// ===== src/tfb_packer.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame packer
// Places the sample fields into the fourteen data bytes and adds the checksum.
// ----------------------------------------------------------------------------
module tfb_packer (
   input  logic              [1:0]  system_status,
   input  logic signed       [7:0]  left_speed,
   input  logic signed       [7:0]  right_speed,
   input  logic signed       [15:0] left_ticks,
   input  logic signed       [15:0] right_ticks,
   input  logic              [7:0]  temperature,
   input  logic signed       [15:0] motor_current,
   input  logic              [7:0]  battery_raw,
   input  logic                     charging,
   input  logic              [7:0]  header_byte,
   input  logic              [5:0]  optional_small,
   input  logic              [15:0] optional_word,
   output tfb_pkg::frame_type       frame
);
   import tfb_pkg::*;

   logic [6:0] bat;
   logic [7:0] even_x;
   logic [7:0] odd_x;
   frame_type  data;

   assign bat = battery_percent(battery_raw);

   // Field packing at fixed bit positions.
   always_comb begin
      data       = '0;
      data[0]    = header_byte;
      data[1]    = {6'd0, system_status};
      data[2]    = left_speed;
      data[3]    = right_speed;
      data[4]    = left_ticks[7:0];
      data[5]    = {right_ticks[1:0], left_ticks[13:8]};
      data[6]    = right_ticks[9:2];
      data[7]    = {6'd0, right_ticks[11:10]};
      data[8]    = {motor_current[0], temperature[6:0]};
      data[9]    = motor_current[8:1];
      data[10]   = {bat[5:0], motor_current[10:9]};
      data[11]   = {optional_small, charging, bat[6]};
      data[12]   = optional_word[7:0];
      data[13]   = optional_word[15:8];
   end

   // Checksum: even bytes fold into the low byte, odd bytes into the high byte.
   always_comb begin
      even_x = '0;
      odd_x  = '0;
      for (int i = 0; i < FRAME_BYTES - 2; i += 2) begin
         even_x = even_x ^ data[i];
         odd_x  = odd_x ^ data[i+1];
      end
   end

   always_comb begin
      frame                  = data;
      frame[FRAME_BYTES-2]   = even_x;
      frame[FRAME_BYTES-1]   = odd_x;
   end

endmodule

// ===== src/tfb_cell.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame byte cell
// One stage of the output shift line: loads a frame byte or takes its neighbor's.
// ----------------------------------------------------------------------------
module tfb_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tfb_pkg::cell_ctrl_type ctrl,
   input  tfb_pkg::cell_type     load_val,
   input  tfb_pkg::cell_type     from_up,
   output tfb_pkg::cell_type     stage_out
);
   import tfb_pkg::*;

   logic       valid_ff, valid_in;
   logic       last_ff,  last_in;
   logic [7:0] data_ff,  data_in;

   // A load wins over a shift; otherwise the cell holds.
   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      if (ctrl.load) begin
         valid_in = load_val.valid;
         last_in  = load_val.last;
         data_in  = load_val.data;
      end else if (ctrl.shift) begin
         valid_in = from_up.valid;
         last_in  = from_up.last;
         data_in  = from_up.data;
      end
   end

   // Occupancy is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Byte payload needs no reset.
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign stage_out = '{valid: valid_ff, last: last_ff, data: data_ff};

endmodule

// ===== src/telemetry_frame_builder.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder
// Turns one telemetry sample into a sixteen-byte frame sent one byte per item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  req_    | in        | req_valid/req_stall| one telemetry sample
//  rsp_    | out       | rsp_valid/rsp_stall| one frame byte, last flag on byte 15
//  csr_    | in        | csr_we             | csr_index, csr_wdata
//
//  A sample is packed into a row of sixteen byte cells in the cycle it is taken.
//  Bytes leave from cell 0 one per cycle while rsp_stall is low; each cell hands
//  its byte down the row. A new sample is taken in the cycle the last byte
//  of the previous frame leaves, so with no stall the frames follow with no gap.
//  Output stalls freeze the whole row; reset empties it and clears the registers.
// ----------------------------------------------------------------------------
module telemetry_frame_builder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [1:0]                   req_system_status,
   input  logic signed [7:0]                   req_left_speed,
   input  logic signed [7:0]                   req_right_speed,
   input  logic signed [15:0]                  req_left_ticks,
   input  logic signed [15:0]                  req_right_ticks,
   input  logic        [7:0]                   req_temperature,
   input  logic signed [15:0]                  req_motor_current,
   input  logic        [7:0]                   req_battery_raw,
   input  logic                                req_charging,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [7:0]                   rsp_frame_byte,
   output logic                                rsp_last_byte,
   input  logic                                csr_we,
   input  logic        [tfb_pkg::IDX_W-1:0]    csr_index,
   input  logic        [tfb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tfb_pkg::*;

   `include "telemetry_frame_builder_assert.svh"

   logic [7:0]    header_ff;
   logic [5:0]    opt_small_ff;
   logic [15:0]   opt_word_ff;
   frame_type     frame;
   cell_ctrl_type ctrl;
   logic          req_take;
   logic          rsp_take;
   cell_type      cells [FRAME_BYTES];
   cell_type      loads [FRAME_BYTES];

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         opt_small_ff <= '0;
         opt_word_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_BYTE:    header_ff    <= csr_wdata[7:0];
            CSR_OPTIONAL_SMALL: opt_small_ff <= csr_wdata[5:0];
            CSR_OPTIONAL_WORD:  opt_word_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   tfb_packer u_packer (
      .system_status  (req_system_status),
      .left_speed     (req_left_speed),
      .right_speed    (req_right_speed),
      .left_ticks     (req_left_ticks),
      .right_ticks    (req_right_ticks),
      .temperature    (req_temperature),
      .motor_current  (req_motor_current),
      .battery_raw    (req_battery_raw),
      .charging       (req_charging),
      .header_byte    (header_ff),
      .optional_small (opt_small_ff),
      .optional_word  (opt_word_ff),
      .frame          (frame)
   );

   // Handshake: the row takes a sample when empty or as its last byte leaves.
   assign rsp_take  = cells[0].valid && !rsp_stall;
   assign req_stall = cells[0].valid && !(cells[0].last && !rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign ctrl      = '{load: req_take, shift: rsp_take};

   // Row of byte cells; the top cell is fed an empty slot.
   for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_cell
      cell_type up_val;
      assign loads[g] = '{valid: 1'b1, last: (g == FRAME_BYTES - 1), data: frame[g]};
      if (g == FRAME_BYTES - 1) begin : g_top
         assign up_val = '{valid: 1'b0, last: 1'b0, data: 8'd0};
      end else begin : g_mid
         assign up_val = cells[g+1];
      end
      tfb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_val  (loads[g]),
         .from_up   (up_val),
         .stage_out (cells[g])
      );
   end

   assign rsp_valid      = cells[0].valid;
   assign rsp_frame_byte = cells[0].data;
   assign rsp_last_byte  = cells[0].last;

   // A frame runs without gaps until its last byte has gone.
   `TFB_ASSERT_NEXT(a_frame_continues, clock, reset, rsp_take && !cells[0].last, rsp_valid, "frame broke off before its last byte")
   // A taken sample fills the row with the last byte at the top.
   `TFB_ASSERT_NEXT(a_load_fills_row, clock, reset, req_take, rsp_valid && cells[FRAME_BYTES-1].valid && cells[FRAME_BYTES-1].last, "sample load did not fill the row")
   // The row holds its bytes contiguously from cell 0.
   `TFB_ASSERT_SAME(a_row_contiguous, clock, reset, cells[1].valid, cells[0].valid && !cells[0].last, "gap or stray byte in the cell row")

endmodule

// ===== bench/telemetry_frame_builder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame builder testbench
// Drives telemetry samples with random gaps and output stalls, predicts the
// sixteen-byte frame of every accepted sample, and checks each frame byte and
// its last flag in order. A directed table runs first, then random phases
// under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_test;
   import tfb_pkg::*;

   // Index outside the register file; a write there must change nothing.
   localparam logic [IDX_W-1:0] CSR_OUT_OF_RANGE = 2'd3;
   localparam int DIRECTED_ROWS = 12;
   localparam int PHASES        = 5;
   localparam int STALL_LIMIT   = 400;
   localparam int DRAIN_CYCLES  = 32;

   // Register settings used by the random phases.
   typedef enum int {SET_ALL_ONES, SET_RANDOM, SET_ZERO} csr_setting_type;

   typedef struct packed {
      logic        [1:0]  system_status;
      logic signed [7:0]  left_speed;
      logic signed [7:0]  right_speed;
      logic signed [15:0] left_ticks;
      logic signed [15:0] right_ticks;
      logic        [7:0]  temperature;
      logic signed [15:0] motor_current;
      logic        [7:0]  battery_raw;
      logic               charging;
   } telemetry_sample_type;

   // One row of the directed table; pinned rows carry a frame typed in by hand.
   typedef struct packed {
      logic                 pinned;
      frame_type            frame;
      telemetry_sample_type sample;
   } stimulus_row_type;

   typedef struct packed {
      logic [3:0] position;
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef struct {
      int              tx_gap_max;
      int              rx_gap_max;
      int              items;
      csr_setting_type setting;
   } phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_system_status = '0;
   logic signed [7:0]     req_left_speed = '0;
   logic signed [7:0]     req_right_speed = '0;
   logic signed [15:0]    req_left_ticks = '0;
   logic signed [15:0]    req_right_ticks = '0;
   logic [7:0]            req_temperature = '0;
   logic signed [15:0]    req_motor_current = '0;
   logic [7:0]            req_battery_raw = '0;
   logic                  req_charging = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_frame_byte;
   logic                  rsp_last_byte;
   logic                  csr_we = 1'b0;
   logic [IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the registers, updated as they are written.
   logic [7:0]  shadow_header = '0;
   logic [5:0]  shadow_small = '0;
   logic [15:0] shadow_word = '0;

   frame_byte_type pending_bytes[$];
   int             tx_gap_max = 9;
   int             rx_gap_max = 9;
   int             error_count = 0;
   int             samples_sent = 0;
   int             bytes_checked = 0;
   int             settings_used = 1;
   int             idle_cycles = 0;

   stimulus_row_type directed_table [DIRECTED_ROWS] = '{
      '{1'b1, 128'h0,
        '{2'd0, 8'sd0, 8'sd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 8'd0, 1'b0}},
      '{1'b1, 128'hFC93_0000_0393_FFFF_03FF_FFFF_FFFF_0300,
        '{2'd3, -8'sd1, -8'sd1, -16'sd1, -16'sd1, 8'd255, -16'sd1, 8'd255, 1'b1}},
      '{1'b0, '0,
        '{2'd1, 8'sd127, -8'sd128, 16'sh7FFF, -16'sh8000, 8'd127, 16'sh7FFF, 8'd1, 1'b0}},
      '{1'b0, '0,
        '{2'd2, -8'sd128, 8'sd127, -16'sh8000, 16'sh7FFF, 8'd128, -16'sh8000, 8'd2, 1'b1}},
      '{1'b0, '0,
        '{2'd0, 8'sd1, -8'sd1, 16'sh2000, 16'sh0800, 8'd0, 16'sh0400, 8'd3, 1'b0}},
      '{1'b0, '0,
        '{2'd3, 8'sd0, 8'sd0, 16'sh4000, 16'sh1000, 8'd64, 16'sh0800, 8'd128, 1'b0}},
      '{1'b0, '0,
        '{2'd1, 8'sd64, 8'sd32, 16'sh00FF, 16'sh0003, 8'd1, 16'sh0001, 8'd254, 1'b1}},
      '{1'b0, '0,
        '{2'd2, 8'sd0, 8'sd0, 16'sh3F00, 16'sh03FC, 8'd0, 16'sh01FE, 8'd51, 1'b0}},
      '{1'b0, '0,
        '{2'd0, 8'sd0, 8'sd0, 16'sd0, 16'sh0C00, 8'd0, 16'sh0600, 8'd50, 1'b0}},
      '{1'b0, '0,
        '{2'd0, 8'sd0, 8'sd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 8'd255, 1'b0}},
      '{1'b0, '0,
        '{2'd0, 8'sd0, 8'sd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 8'd0, 1'b1}},
      '{1'b0, '0,
        '{2'd3, -8'sd2, 8'sd2, -16'sd2, -16'sd3, 8'd200, -16'sd5, 8'd160, 1'b1}}
   };

   phase_type phase_plan [PHASES] = '{
      '{9, 9, 45, SET_ALL_ONES},
      '{0, 0, 45, SET_RANDOM},
      '{9, 0, 40, SET_ZERO},
      '{0, 9, 40, SET_RANDOM},
      '{9, 9, 40, SET_RANDOM}
   };

   telemetry_frame_builder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_system_status (req_system_status),
      .req_left_speed    (req_left_speed),
      .req_right_speed   (req_right_speed),
      .req_left_ticks    (req_left_ticks),
      .req_right_ticks   (req_right_ticks),
      .req_temperature   (req_temperature),
      .req_motor_current (req_motor_current),
      .req_battery_raw   (req_battery_raw),
      .req_charging      (req_charging),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pack one sample into the sixteen frame bytes, checksum included.
   function automatic frame_type pack_frame(input telemetry_sample_type s,
                                            input logic [7:0] header,
                                            input logic [5:0] small_field,
                                            input logic [15:0] word_field);
      frame_type   f;
      logic [13:0] left_low;
      logic [11:0] right_low;
      logic [10:0] current_low;
      logic [14:0] scaled;
      logic [6:0]  percent;
      logic [7:0]  even_sum;
      logic [7:0]  odd_sum;
      left_low    = s.left_ticks[13:0];
      right_low   = s.right_ticks[11:0];
      current_low = s.motor_current[10:0];
      scaled      = 15'(s.battery_raw) * 15'd100;
      percent     = 7'(scaled / 15'd255);
      f[0]  = header;
      f[1]  = {6'b0, s.system_status};
      f[2]  = s.left_speed;
      f[3]  = s.right_speed;
      f[4]  = left_low[7:0];
      f[5]  = {right_low[1:0], left_low[13:8]};
      f[6]  = right_low[9:2];
      f[7]  = {6'b0, right_low[11:10]};
      f[8]  = {current_low[0], s.temperature[6:0]};
      f[9]  = current_low[8:1];
      f[10] = {percent[5:0], current_low[10:9]};
      f[11] = {small_field, s.charging, percent[6]};
      f[12] = word_field[7:0];
      f[13] = word_field[15:8];
      even_sum = '0;
      odd_sum  = '0;
      for (int k = 0; k < FRAME_BYTES - 2; k += 2) begin
         even_sum ^= f[k];
         odd_sum  ^= f[k + 1];
      end
      f[14] = even_sum;
      f[15] = odd_sum;
      return f;
   endfunction

   // Random sample; some fields are pulled to their extremes now and then.
   function automatic telemetry_sample_type random_sample();
      telemetry_sample_type s;
      s.system_status = 2'($urandom);
      s.left_speed    = 8'($urandom);
      s.right_speed   = 8'($urandom);
      s.left_ticks    = 16'($urandom);
      s.right_ticks   = 16'($urandom);
      s.temperature   = 8'($urandom);
      s.motor_current = 16'($urandom);
      s.battery_raw   = 8'($urandom);
      s.charging      = 1'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         s.left_ticks = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      end
      if ($urandom_range(0, 7) == 0) begin
         s.right_ticks = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      end
      if ($urandom_range(0, 7) == 0) begin
         s.motor_current = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      end
      if ($urandom_range(0, 5) == 0) begin
         s.battery_raw = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      return s;
   endfunction

   // Offer one sample after a random gap and queue its frame once accepted.
   task automatic send_sample(input telemetry_sample_type s, input logic pinned,
                              input frame_type pinned_frame);
      int        gap;
      frame_type f;
      gap = $urandom_range(0, tx_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_system_status <= s.system_status;
      req_left_speed    <= s.left_speed;
      req_right_speed   <= s.right_speed;
      req_left_ticks    <= s.left_ticks;
      req_right_ticks   <= s.right_ticks;
      req_temperature   <= s.temperature;
      req_motor_current <= s.motor_current;
      req_battery_raw   <= s.battery_raw;
      req_charging      <= s.charging;
      do @(posedge clock); while (!(req_valid && !req_stall));
      f = pinned ? pinned_frame : pack_frame(s, shadow_header, shadow_small, shadow_word);
      for (int k = 0; k < FRAME_BYTES; k++) begin
         pending_bytes.push_back('{4'(k), f[k], k == FRAME_BYTES - 1});
      end
      samples_sent++;
   endtask

   // Drop the request and wait until every queued frame byte has come out.
   task automatic drain_frames();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
   endtask

   // One register write; the shadow copy keeps only the bits the register holds.
   task automatic write_csr(input logic [IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_HEADER_BYTE:    shadow_header = data[7:0];
         CSR_OPTIONAL_SMALL: shadow_small  = data[5:0];
         CSR_OPTIONAL_WORD:  shadow_word   = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Receiver: stall a random number of cycles before taking each byte.
   initial begin
      int gap;
      forever begin
         gap = $urandom_range(0, rx_gap_max);
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Compare every accepted frame byte with the oldest expectation.
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            error_count++;
            $display("%0t: expected no byte, got frame byte %02h last %0b", $time,
                     rsp_frame_byte, rsp_last_byte);
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_frame_byte !== want.data || rsp_last_byte !== want.last) begin
               error_count++;
               $display("%0t: byte %0d expected %02h last %0b, got %02h last %0b",
                        $time, want.position, want.data, want.last,
                        rsp_frame_byte, rsp_last_byte);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed table with the registers still at their reset values.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_sample(directed_table[r].sample, directed_table[r].pinned,
                     directed_table[r].frame);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_frames();
         // The out-of-range index gets random data and must stay harmless.
         write_csr(CSR_OUT_OF_RANGE, 16'($urandom));
         case (phase_plan[p].setting)
            SET_ALL_ONES: begin
               write_csr(CSR_HEADER_BYTE, 16'hFFFF);
               write_csr(CSR_OPTIONAL_SMALL, 16'hFFFF);
               write_csr(CSR_OPTIONAL_WORD, 16'hFFFF);
            end
            SET_ZERO: begin
               write_csr(CSR_HEADER_BYTE, 16'h0000);
               write_csr(CSR_OPTIONAL_SMALL, 16'h0000);
               write_csr(CSR_OPTIONAL_WORD, 16'h0000);
            end
            default: begin
               write_csr(CSR_HEADER_BYTE, 16'($urandom));
               write_csr(CSR_OPTIONAL_SMALL, 16'($urandom));
               write_csr(CSR_OPTIONAL_WORD, 16'($urandom));
            end
         endcase
         settings_used++;
         tx_gap_max = phase_plan[p].tx_gap_max;
         rx_gap_max = phase_plan[p].rx_gap_max;
         for (int n = 0; n < phase_plan[p].items; n++) begin
            send_sample(random_sample(), 1'b0, '0);
         end
      end

      drain_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d samples (%0d from the directed table) under %0d register settings,",
               samples_sent, DIRECTED_ROWS, settings_used);
      $display("and checked %0d frame bytes with %0d mismatches.", bytes_checked, error_count);
      if (error_count == 0 && pending_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== telemetry_frame_builder.f =====
+incdir+src
src/tfb_pkg.sv
src/tfb_packer.sv
src/tfb_cell.sv
src/telemetry_frame_builder.sv
bench/telemetry_frame_builder_test.sv
